@@ hw/rtl/lidar_frame_parse_calibrate_core_macros.svh @@
// Assertion macros shared by the lidar frame parser RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LIDAR_FRAME_PARSE_CALIBRATE_CORE_MACROS_SVH
`define LIDAR_FRAME_PARSE_CALIBRATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfpc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfpc assertion failed");

`endif

@@ hw/rtl/lfpc_pkg.sv @@
// Types and constants of the lidar frame parser and calibrator.
// No dependencies; imported by every module of the block but lfpc_queue.
`default_nettype none

package lfpc_pkg;

    localparam int FRAME_BYTES = 7;
    localparam logic [2:0] LAST_BODY_IDX = 3'(FRAME_BYTES - 1);

    localparam logic [7:0] HDR_BYTE = 8'h59;
    localparam logic [7:0] SUM_SEED = 8'hB2;

    // floor(m / 100) == (m * RECIP_100) >> RECIP_SHIFT for every m below 2**23
    localparam int RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP_100 = 24'd10737419;
    localparam logic signed [37:0] ROUND_HALF = 38'sd50;
    // n + 50 at or above this gives more than 65535 after the divide
    localparam logic signed [37:0] SAT_BOUND = 38'sd6553600;

    typedef enum logic [2:0] {
        CFG_GAIN_CENTI  = 3'd0,
        CFG_OFFSET_MM   = 3'd1,
        CFG_MAX_DIST_MM = 3'd2,
        CFG_MIN_DIST_MM = 3'd3,
        CFG_SKIP_LIMIT  = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_OVERFLOW  = 3'd1,
        STAT_UNDERFLOW = 3'd2,
        STAT_BAD_SUM   = 3'd3,
        STAT_NO_HEADER = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        JOB_GOOD    = 2'd0,
        JOB_BAD_SUM = 2'd1,
        JOB_NO_HDR  = 2'd2
    } job_kind_t;

    typedef enum logic {
        PS_HUNT = 1'b0,
        PS_BODY = 1'b1
    } parse_state_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] raw_cm;
    } job_t;

    typedef struct packed {
        logic [15:0]        gain_centi;
        logic signed [15:0] offset_mm;
        logic [15:0]        max_dist_mm;
        logic [15:0]        min_dist_mm;
        logic [7:0]         skip_limit;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/lidar_frame_parse_calibrate_core.sv @@
// Range sensor serial frame parser with distance calibration.
// Channels: rx_byte in on in_valid/in_ready; one result (distance_mm,
// status) out on out_valid/out_ready per finished frame or missing header.
// Configuration: write cfg_wdata to register cfg_index while cfg_wr_en is
// high (0 gain, 1 offset, 2 max limit, 3 min limit, 4 skip limit); write
// only while no result is pending.
// Throughput: one byte per clock. The parser takes a byte every cycle while
// the four-stage calibration pipeline and its job queue keep up.
// Path: a job posted at the edge that accepts the checksum byte (or the
// byte that exhausts the skip limit) passes the job queue, the gain
// multiply, the offset add and the reciprocal multiply that divides by
// 100, and then shows on out_valid from the output register.
// Receiver stall: the output register holds its result and the pipeline
// holds; the queue absorbs QUEUE_DEPTH jobs and in_ready falls once full.
// Reset: registers take their reset values, the parser hunts for a header,
// the queue and pipeline empty. No clearing pass is needed.
// Depends on lfpc_pkg, lfpc_front, lfpc_queue, lfpc_back.
`default_nettype none

module lidar_frame_parse_calibrate_core
    import lfpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      distance_mm,
    output logic [2:0]       status
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic queue_full;
    logic push;
    job_t push_job;
    logic job_valid;
    job_t job;
    logic job_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_GAIN_CENTI:  cfg_next.gain_centi  = cfg_wdata;
                CFG_OFFSET_MM:   cfg_next.offset_mm   = $signed(cfg_wdata);
                CFG_MAX_DIST_MM: cfg_next.max_dist_mm = cfg_wdata;
                CFG_MIN_DIST_MM: cfg_next.min_dist_mm = cfg_wdata;
                CFG_SKIP_LIMIT:  cfg_next.skip_limit  = cfg_wdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_centi  <= 16'd100;
            cfg_reg.offset_mm   <= 16'sd0;
            cfg_reg.max_dist_mm <= 16'd12000;
            cfg_reg.min_dist_mm <= 16'd300;
            cfg_reg.skip_limit  <= 8'd32;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lfpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .skip_limit (cfg_reg.skip_limit),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    lfpc_queue #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .pop_data  (job)
    );

    lfpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job_valid   (job_valid),
        .job         (job),
        .job_pop     (job_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance_mm (distance_mm),
        .status      (status)
    );

endmodule

`default_nettype wire

@@ hw/rtl/lfpc_queue.sv @@
// Short register FIFO that decouples the frame parser from the calibrator.
// Generic in width and depth; no package dependency.
`default_nettype none
`include "lidar_frame_parse_calibrate_core_macros.svh"

module lfpc_queue #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // a push into a full queue would drop a job
    `LFPC_ASSERT_NOW(a_no_push_when_full, clk, rst_n, full, !push)
    `LFPC_ASSERT_NEXT(a_count_bounded, clk, rst_n, 1'b1, count_reg <= FULL_CNT)

endmodule

`default_nettype wire

@@ hw/rtl/lfpc_front.sv @@
// Front end: accepts received bytes, hunts for the header, checks the sum
// and posts one job per finished frame or missing header. Uses lfpc_pkg.
`default_nettype none
`include "lidar_frame_parse_calibrate_core_macros.svh"

module lfpc_front
    import lfpc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] skip_limit,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       queue_full,
    output logic            push,
    output job_t            push_job
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic [7:0]   prev_reg;
    logic [7:0]   prev_next;
    logic [7:0]   skip_reg;
    logic [7:0]   skip_next;
    logic [2:0]   idx_reg;
    logic [2:0]   idx_next;
    logic [7:0]   sum_reg;
    logic [7:0]   sum_next;
    logic [15:0]  raw_reg;
    logic [15:0]  raw_next;

    assign in_ready = !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_HUNT;
            prev_reg  <= '0;
            skip_reg  <= '0;
            idx_reg   <= '0;
            sum_reg   <= SUM_SEED;
            raw_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            skip_reg  <= skip_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            raw_reg   <= raw_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        prev_next       = prev_reg;
        skip_next       = skip_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        raw_next        = raw_reg;
        push            = 1'b0;
        push_job.kind   = JOB_GOOD;
        push_job.raw_cm = raw_reg;
        if (in_valid && in_ready)
        begin
            unique case (state_reg)
                PS_HUNT:
                begin
                    if (prev_reg == HDR_BYTE && rx_byte == HDR_BYTE)
                    begin
                        state_next = PS_BODY;
                        prev_next  = '0;
                        skip_next  = '0;
                        idx_next   = '0;
                        sum_next   = SUM_SEED;
                    end
                    else if (skip_reg >= skip_limit)
                    begin
                        // give up on this stretch and restart the hunt
                        prev_next     = '0;
                        skip_next     = '0;
                        idx_next      = '0;
                        push          = 1'b1;
                        push_job.kind = JOB_NO_HDR;
                    end
                    else
                    begin
                        prev_next = rx_byte;
                        skip_next = skip_reg + 8'd1;
                    end
                end
                PS_BODY:
                begin
                    if (idx_reg >= LAST_BODY_IDX)
                    begin
                        state_next    = PS_HUNT;
                        prev_next     = '0;
                        skip_next     = '0;
                        idx_next      = '0;
                        push          = 1'b1;
                        push_job.kind = (sum_reg == rx_byte) ? JOB_GOOD : JOB_BAD_SUM;
                    end
                    else
                    begin
                        if (idx_reg == 3'd0)
                        begin
                            raw_next[7:0] = rx_byte;
                        end
                        else if (idx_reg == 3'd1)
                        begin
                            raw_next[15:8] = rx_byte;
                        end
                        sum_next = sum_reg + rx_byte;
                        idx_next = idx_reg + 3'd1;
                    end
                end
            endcase
        end
    end

    `LFPC_ASSERT_NOW(a_hunt_idx_zero, clk, rst_n, state_reg == PS_HUNT, idx_reg == 3'd0)
    `LFPC_ASSERT_NOW(a_body_clean, clk, rst_n, state_reg == PS_BODY,
                     skip_reg == 8'd0 && prev_reg == 8'd0)

endmodule

`default_nettype wire

@@ hw/rtl/lfpc_back.sv @@
// Back end: calibration pipeline (scale, gain, offset, round, saturate,
// classify) and the output register. Uses lfpc_pkg.
`default_nettype none
`include "lidar_frame_parse_calibrate_core_macros.svh"

module lfpc_back
    import lfpc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  job_valid,
    input  wire job_t  job,
    output logic       job_pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [15:0] distance_mm,
    output logic [2:0]  status
);

    logic               advance;

    logic               s1_valid_reg;
    job_kind_t          s1_kind_reg;
    logic [35:0]        s1_prod_reg;

    logic               s2_valid_reg;
    job_kind_t          s2_kind_reg;
    logic               s2_neg_reg;
    logic               s2_sat_reg;
    logic [22:0]        s2_m_reg;

    logic               s3_valid_reg;
    job_kind_t          s3_kind_reg;
    logic               s3_neg_reg;
    logic               s3_sat_reg;
    logic [46:0]        s3_prod_reg;

    logic               out_valid_reg;
    logic [15:0]        dist_reg;
    status_t            status_reg;

    logic [19:0]        mm;
    logic signed [22:0] off_ext;
    logic signed [22:0] off100;
    logic signed [37:0] n_s;
    logic signed [37:0] m_s;
    logic [15:0]        quot;
    logic [15:0]        dist_next;
    status_t            status_next;

    // the whole pipeline holds while a result waits on the receiver
    assign advance = !out_valid_reg || out_ready;
    assign job_pop = advance && job_valid;

    assign mm      = {1'b0, job.raw_cm, 3'b000} + {3'b000, job.raw_cm, 1'b0};
    assign off_ext = 23'(cfg.offset_mm);
    assign off100  = (off_ext <<< 6) + (off_ext <<< 5) + (off_ext <<< 2);
    assign n_s     = $signed({2'b00, s1_prod_reg}) + 38'(off100);
    assign m_s     = n_s + ROUND_HALF;
    assign quot    = s3_prod_reg[RECIP_SHIFT+15:RECIP_SHIFT];

    always_comb
    begin
        if (s3_neg_reg)
        begin
            dist_next = '0;
        end
        else if (s3_sat_reg)
        begin
            dist_next = 16'hFFFF;
        end
        else
        begin
            dist_next = quot;
        end
        status_next = STAT_OK;
        unique case (s3_kind_reg)
            JOB_GOOD:
            begin
                priority if (dist_next >= cfg.max_dist_mm)
                begin
                    status_next = STAT_OVERFLOW;
                end
                else if (dist_next <= cfg.min_dist_mm)
                begin
                    status_next = STAT_UNDERFLOW;
                end
                else
                begin
                    status_next = STAT_OK;
                end
            end
            JOB_BAD_SUM:
            begin
                dist_next   = '0;
                status_next = STAT_BAD_SUM;
            end
            JOB_NO_HDR:
            begin
                dist_next   = '0;
                status_next = STAT_NO_HEADER;
            end
            default:
            begin
                dist_next   = '0;
                status_next = STAT_NO_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg <= job.kind;
            s1_prod_reg <= 36'(mm) * 36'(cfg.gain_centi);

            s2_kind_reg <= s1_kind_reg;
            s2_neg_reg  <= n_s[37];
            s2_sat_reg  <= !n_s[37] && (m_s >= SAT_BOUND);
            s2_m_reg    <= m_s[22:0];

            s3_kind_reg <= s2_kind_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_sat_reg  <= s2_sat_reg;
            s3_prod_reg <= 47'(s2_m_reg) * 47'(RECIP_100);

            dist_reg    <= dist_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign distance_mm = dist_reg;
    assign status      = status_reg;

    `LFPC_ASSERT_NOW(a_neg_sat_exclusive, clk, rst_n, s2_valid_reg, !(s2_neg_reg && s2_sat_reg))
    `LFPC_ASSERT_NOW(a_error_zero_dist, clk, rst_n,
                     out_valid_reg && (status_reg == STAT_BAD_SUM || status_reg == STAT_NO_HEADER),
                     dist_reg == 16'd0)

endmodule

`default_nettype wire

@@ tb/lidar_frame_parse_calibrate_core_tb.sv @@
// Testbench for lidar_frame_parse_calibrate_core: serial byte stream in, calibrated
// distance readings out, checked against an in-bench parser and calibration model.
// Depends on lfpc_pkg and the core RTL only.
module lidar_frame_parse_calibrate_core_tb;
    import lfpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned RANDOM_BYTES = 700;

    typedef struct packed {
        logic [15:0] dist_mm;
        status_t     code;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] distance_mm;
    logic [2:0]  status;

    lidar_frame_parse_calibrate_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .distance_mm(distance_mm),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the calibration registers and the parser state.
    cfg_t        cal_cfg;
    logic        hunt_in_frame = 1'b0;
    logic [7:0]  hunt_prev = '0;
    logic [7:0]  hunt_skipped = '0;
    logic [2:0]  body_idx = '0;
    logic [7:0]  body_sum = SUM_SEED;
    logic [15:0] frame_raw_cm = '0;

    logic [7:0]  byte_q[$];
    reading_t    reading_q[$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    function automatic logic [15:0] scale_distance(logic [15:0] raw_cm);
        longint n;
        longint d;
        n = longint'(raw_cm) * 10 * longint'(cal_cfg.gain_centi)
            + longint'($signed(cal_cfg.offset_mm)) * 100;
        if (n < 0)
            return 16'd0;
        d = (n + 50) / 100;
        if (d > 65535)
            d = 65535;
        return 16'(d);
    endfunction

    function automatic void restart_hunt();
        hunt_in_frame = 1'b0;
        hunt_prev = '0;
        hunt_skipped = '0;
        body_idx = '0;
    endfunction

    // Advance the parser by one byte; queue the reading it produces, if any.
    function automatic void take_byte(logic [7:0] b);
        logic [15:0] cal_dist;
        status_t     st;
        if (!hunt_in_frame) begin
            if (hunt_prev == HDR_BYTE && b == HDR_BYTE) begin
                restart_hunt();
                hunt_in_frame = 1'b1;
                body_sum = SUM_SEED;
                return;
            end
            hunt_prev = b;
            if (hunt_skipped >= cal_cfg.skip_limit) begin
                restart_hunt();
                reading_q.push_back('{dist_mm: 16'd0, code: STAT_NO_HEADER});
                return;
            end
            hunt_skipped = hunt_skipped + 8'd1;
            return;
        end
        if (body_idx >= LAST_BODY_IDX) begin
            restart_hunt();
            if (body_sum != b) begin
                reading_q.push_back('{dist_mm: 16'd0, code: STAT_BAD_SUM});
                return;
            end
            cal_dist = scale_distance(frame_raw_cm);
            if (cal_dist >= cal_cfg.max_dist_mm)
                st = STAT_OVERFLOW;
            else if (cal_dist <= cal_cfg.min_dist_mm)
                st = STAT_UNDERFLOW;
            else
                st = STAT_OK;
            reading_q.push_back('{dist_mm: cal_dist, code: st});
            return;
        end
        if (body_idx == 3'd0)
            frame_raw_cm[7:0] = b;
        else if (body_idx == 3'd1)
            frame_raw_cm[15:8] = b;
        body_sum = body_sum + b;
        body_idx = body_idx + 3'd1;
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        byte_q.push_back(b);
        bytes_queued++;
    endfunction

    // Full frame when cut is FRAME_BYTES, otherwise only the first cut body bytes.
    function automatic void queue_frame(logic [15:0] raw_cm, bit bad_sum, int cut);
        logic [7:0] sum;
        logic [7:0] b;
        sum = SUM_SEED;
        queue_byte(HDR_BYTE);
        queue_byte(HDR_BYTE);
        for (int k = 0; k < FRAME_BYTES - 1 && k < cut; k++) begin
            b = (k == 0) ? raw_cm[7:0] : (k == 1) ? raw_cm[15:8] : 8'($urandom);
            sum = sum + b;
            queue_byte(b);
        end
        if (cut >= FRAME_BYTES)
            queue_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    endfunction

    function automatic void queue_noise(int count);
        for (int k = 0; k < count; k++)
            queue_byte(($urandom_range(0, 5) == 0) ? HDR_BYTE : 8'($urandom));
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_GAIN_CENTI:  cal_cfg.gain_centi = val;
            CFG_OFFSET_MM:   cal_cfg.offset_mm = val;
            CFG_MAX_DIST_MM: cal_cfg.max_dist_mm = val;
            CFG_MIN_DIST_MM: cal_cfg.min_dist_mm = val;
            CFG_SKIP_LIMIT:  cal_cfg.skip_limit = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_cal(input logic [15:0] gain, input logic [15:0] offset,
                           input logic [15:0] max_mm, input logic [15:0] min_mm,
                           input logic [7:0] skip);
        write_reg(CFG_GAIN_CENTI, gain);
        write_reg(CFG_OFFSET_MM, offset);
        write_reg(CFG_MAX_DIST_MM, max_mm);
        write_reg(CFG_MIN_DIST_MM, min_mm);
        write_reg(CFG_SKIP_LIMIT, {8'h00, skip});
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every byte is taken and every reading has come out.
    task automatic settle();
        while (bytes_taken != bytes_queued || reading_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_raw_cm();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (sel < 6)
            return 16'($urandom_range(0, 1500));
        return 16'($urandom);
    endfunction

    always @(posedge clk)
    begin : byte_driver
        logic presenting;
        if (rst_n) begin
            presenting = in_valid;
            if (in_valid && in_ready) begin
                take_byte(rx_byte);
                bytes_taken++;
                presenting = 1'b0;
                if ($urandom_range(0, 47) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 12);
            end
            if (!presenting) begin
                if (send_gap != 0)
                    send_gap--;
                else if (byte_q.size() != 0) begin
                    rx_byte <= byte_q.pop_front();
                    presenting = 1'b1;
                end
            end
            in_valid <= presenting;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        logic     ready_next;
        reading_t want;
        if (rst_n) begin
            ready_next = out_ready;
            if (out_valid && out_ready) begin
                if (reading_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected reading: distance %0d status %0d",
                                 distance_mm, status);
                    mismatches++;
                end else begin
                    want = reading_q.pop_front();
                    if (distance_mm !== want.dist_mm || status !== want.code) begin
                        if (mismatches < 10)
                            $display("reading mismatch: distance %0d/%0d status %0d/%0d",
                                     distance_mm, want.dist_mm, status, want.code);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 47) == 0)
                    recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 12);
                ready_next = (recv_stall == 0);
            end else if (!out_ready) begin
                if (recv_stall != 0)
                    recv_stall--;
                ready_next = (recv_stall == 0);
            end
            out_ready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_bytes;
        int unsigned phase_end;
        int unsigned sel;
        logic [7:0]  skip;
        cal_cfg.gain_centi = 16'd100;
        cal_cfg.offset_mm = 16'sd0;
        cal_cfg.max_dist_mm = 16'd12000;
        cal_cfg.min_dist_mm = 16'd300;
        cal_cfg.skip_limit = 8'd32;
        random_bytes = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: saturated overflow, bad checksum, lone header byte, plain hit.
        queue_frame(16'hFFFF, 1'b0, FRAME_BYTES);
        queue_frame(16'h0000, 1'b1, FRAME_BYTES);
        queue_byte(HDR_BYTE);
        queue_byte(8'h00);
        queue_frame(16'd100, 1'b0, FRAME_BYTES);
        settle();

        // With a zero skip limit every byte, frame bytes included, reports a missing header.
        set_cal(16'd0, 16'h8000, 16'hFFFF, 16'd0, 8'd0);
        queue_frame(16'h1234, 1'b0, FRAME_BYTES);
        queue_noise(3);
        settle();

        // Both limits hit at once: overflow wins.
        set_cal(16'hFFFF, 16'h7FFF, 16'd0, 16'hFFFF, 8'd255);
        queue_frame(16'hFFFF, 1'b0, FRAME_BYTES);
        queue_frame(16'h0000, 1'b0, FRAME_BYTES);
        settle();

        // Halves round away from zero.
        set_cal(16'd15, 16'd0, 16'd12000, 16'd0, 8'd8);
        queue_frame(16'd1, 1'b0, FRAME_BYTES);
        queue_frame(16'd3, 1'b0, FRAME_BYTES);
        settle();

        while (random_bytes < RANDOM_BYTES) begin
            sel = $urandom_range(0, 5);
            skip = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(2, 24));
            set_cal(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(80, 125)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 1000) - 500),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(4000, 14000)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)),
                    skip);
            phase_end = bytes_queued + $urandom_range(60, 140);
            while (bytes_queued < phase_end) begin
                sel = $urandom_range(0, 99);
                if (sel < 65)
                    queue_frame(pick_raw_cm(), 1'b0, FRAME_BYTES);
                else if (sel < 75)
                    queue_frame(pick_raw_cm(), 1'b1, FRAME_BYTES);
                else if (sel < 82)
                    queue_frame(pick_raw_cm(), 1'b0, $urandom_range(0, FRAME_BYTES - 1));
                else
                    queue_noise($urandom_range(1, 30));
            end
            settle();
            random_bytes = bytes_queued;
        end

        settle();
        if (mismatches == 0 && reading_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
